@@ design/rcdq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcdq_pkg
// shared types and constants of the restricted circular deque
// ----------------------------------------------------------------------------
package rcdq_pkg;

  localparam int WORD_W    = 32;
  localparam int OP_W      = 3;
  localparam int STAT_W    = 2;
  localparam int CAP_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int RUN_MAX   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(RUN_MAX);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_REAR  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_LIST       = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_ILLEGAL   = 2'd3
  } stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 1'd0,
    CFG_MODE     = 1'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LIST = 3'b100
  } state_t;

endpackage

`default_nettype wire

@@ design/restricted_circular_deque_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// restricted_circular_deque_core
// circular double-ended queue with input- or output-restricted op set
// ----------------------------------------------------------------------------
// Words live in a single ring memory with registered reads; front and rear
// pointers, the empty flag and the two config registers sit in the
// controller. Pushes, clears, rejected ops and empty/full results load the
// output register from the idle state. A pop starts the ring read from idle
// and loads the word in S_READ. A list starts the first read from idle, then
// loads one word per cycle while the output register can be loaded. The block
// takes the next op once its last result is in the output register and that
// register can be loaded again. Writing capacity empties the queue; writing
// the mode keeps the contents. The ring needs no clearing pass after reset.
module restricted_circular_deque_core
  import rcdq_pkg::*;
#(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [OP_W-1:0]      in_op,
  input  wire logic signed [WORD_W-1:0] in_value,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CAP_W-1:0]     cfg_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [WORD_W-1:0]  out_word,
  output logic      [STAT_W-1:0]    out_status,
  output logic                      out_last
);

  localparam int AW = $clog2(DEPTH);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic [WORD_W-1:0]     word_w;

  rcdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_value   (in_value),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (word_w),
    .out_status (out_status),
    .out_last   (out_last),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  rcdq_ring #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_word = word_w;

endmodule

`default_nettype wire

@@ design/rcdq_ring.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcdq_ring
// ring storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module rcdq_ring #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 5
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output logic      [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/rcdq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcdq_ctrl
// deque control: front and rear pointers, op decode, list walk, result register
// ----------------------------------------------------------------------------
module rcdq_ctrl
  import rcdq_pkg::*;
#(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [WORD_W-1:0]     in_value,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CAP_W-1:0]      cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [WORD_W-1:0]     out_word,
  output logic      [STAT_W-1:0]     out_status,
  output logic                       out_last,
  output logic                       mem_we,
  output logic      [AW-1:0]         mem_waddr,
  output logic      [DATA_WIDTH-1:0] mem_wdata,
  output logic                       mem_re,
  output logic      [AW-1:0]         mem_raddr,
  input  wire logic [DATA_WIDTH-1:0] mem_rdata
);

  localparam int LIMIT = (DEPTH < RUN_MAX) ? DEPTH : RUN_MAX;
  localparam int PW    = ((AW > CAP_W) ? AW : CAP_W) + 1;

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p,
                                             input logic [CAP_W-1:0] c);
    logic [PW-1:0] pe;
    pe = PW'(p) + PW'(1);
    return (pe >= PW'(c)) ? '0 : AW'(pe);
  endfunction

  function automatic logic [AW-1:0] prev_pos(input logic [AW-1:0] p,
                                             input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] cm;
    cm = c - CAP_W'(1);
    return (p == '0) ? AW'(cm) : p - AW'(1);
  endfunction

  state_t           state_r, state_nxt;
  logic [AW-1:0]    front_r, front_nxt;
  logic [AW-1:0]    rear_r, rear_nxt;
  logic             empty_r, empty_nxt;
  logic [AW-1:0]    lp_r, lp_nxt;
  logic [CAP_W-1:0] k_r, k_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             mode_r, mode_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r;
  stat_t            out_status_r;
  logic             out_last_r;

  logic [CAP_W-1:0] used;
  logic             can_load;
  logic             in_acc;
  logic             full;
  logic             forbidden;
  logic             list_end;
  logic [AW-1:0]    rear_fwd, front_bwd, front_fwd, rear_bwd, lp_fwd;
  op_t              op;
  logic             load;
  logic [WORD_W-1:0] ld_word;
  stat_t            ld_status;
  logic             ld_last;

  always_comb begin
    if (cap_r == '0) begin
      used = CAP_W'(1);
    end else if (cap_r > CAP_W'(LIMIT)) begin
      used = CAP_W'(LIMIT);
    end else begin
      used = cap_r;
    end
  end

  assign rear_fwd  = next_pos(rear_r, used);
  assign front_bwd = prev_pos(front_r, used);
  assign front_fwd = next_pos(front_r, used);
  assign rear_bwd  = prev_pos(rear_r, used);
  assign lp_fwd    = next_pos(lp_r, used);

  assign full      = !empty_r && (rear_fwd == front_r);
  assign op        = op_t'(in_op);
  assign forbidden = (in_op > OP_CLEAR) ||
                     ((op == OP_PUSH_FRONT) && !mode_r) ||
                     ((op == OP_POP_REAR) && mode_r);
  assign list_end  = (lp_r == rear_r) || (CAP_W'(k_r + CAP_W'(1)) >= used);

  assign can_load = !out_valid_r || !out_stall;
  assign in_acc   = in_valid && (state_r == S_IDLE) && can_load;
  assign in_stall = !((state_r == S_IDLE) && can_load);

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    rear_nxt  = rear_r;
    empty_nxt = empty_r;
    lp_nxt    = lp_r;
    k_nxt     = k_r;
    cap_nxt   = cap_r;
    mode_nxt  = mode_r;
    mem_we    = 1'b0;
    mem_waddr = front_r;
    mem_wdata = DATA_WIDTH'($unsigned(in_value));
    mem_re    = 1'b0;
    mem_raddr = front_r;
    load      = 1'b0;
    ld_word   = '0;
    ld_status = STAT_OK;
    ld_last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          load = 1'b1;
          if (forbidden) begin
            ld_status = STAT_ILLEGAL;
          end else begin
            unique case (op) inside
              OP_PUSH_REAR, OP_PUSH_FRONT: begin
                if (full) begin
                  ld_status = STAT_OVERFLOW;
                end else begin
                  mem_we = 1'b1;
                  if (empty_r) begin
                    rear_nxt  = front_r;
                    empty_nxt = 1'b0;
                    mem_waddr = front_r;
                  end else if (op == OP_PUSH_REAR) begin
                    rear_nxt  = rear_fwd;
                    mem_waddr = rear_fwd;
                  end else begin
                    front_nxt = front_bwd;
                    mem_waddr = front_bwd;
                  end
                end
              end
              OP_POP_FRONT, OP_POP_REAR: begin
                if (empty_r) begin
                  ld_status = STAT_UNDERFLOW;
                end else begin
                  load      = 1'b0;
                  mem_re    = 1'b1;
                  mem_raddr = (op == OP_POP_FRONT) ? front_r : rear_r;
                  state_nxt = S_READ;
                  if (front_r == rear_r) begin
                    empty_nxt = 1'b1;
                  end else if (op == OP_POP_FRONT) begin
                    front_nxt = front_fwd;
                  end else begin
                    rear_nxt = rear_bwd;
                  end
                end
              end
              OP_LIST: begin
                if (empty_r) begin
                  ld_status = STAT_UNDERFLOW;
                end else begin
                  load      = 1'b0;
                  mem_re    = 1'b1;
                  mem_raddr = front_r;
                  lp_nxt    = front_r;
                  k_nxt     = '0;
                  state_nxt = S_LIST;
                end
              end
              OP_CLEAR: begin
                front_nxt = '0;
                rear_nxt  = '0;
                empty_nxt = 1'b1;
              end
              default: begin
                ld_status = STAT_ILLEGAL;
              end
            endcase
          end
        end
      end
      S_READ: begin
        if (can_load) begin
          load      = 1'b1;
          ld_word   = WORD_W'(mem_rdata);
          state_nxt = S_IDLE;
        end
      end
      S_LIST: begin
        if (can_load) begin
          load    = 1'b1;
          ld_word = WORD_W'(mem_rdata);
          ld_last = list_end;
          if (list_end) begin
            state_nxt = S_IDLE;
          end else begin
            lp_nxt    = lp_fwd;
            k_nxt     = CAP_W'(k_r + CAP_W'(1));
            mem_re    = 1'b1;
            mem_raddr = lp_fwd;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAPACITY: begin
          cap_nxt   = cfg_data;
          front_nxt = '0;
          rear_nxt  = '0;
          empty_nxt = 1'b1;
        end
        CFG_MODE: begin
          mode_nxt = cfg_data[0];
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  assign out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      rear_r      <= '0;
      empty_r     <= 1'b1;
      lp_r        <= '0;
      k_r         <= '0;
      cap_r       <= CAP_RESET;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      empty_r     <= empty_nxt;
      lp_r        <= lp_nxt;
      k_r         <= k_nxt;
      cap_r       <= cap_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r   <= ld_word;
      out_status_r <= ld_status;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire
